/* hw/rtl/u8u16_pkg.sv */
// shared types, constants and decode functions for the utf-8 to utf-16 transcoder
package u8u16_pkg;

    localparam int UNITS_MAX = 3;

    localparam logic [7:0] ASCII_LIMIT = 8'h80;
    localparam logic [7:0] MASK_3BIT   = 8'hE0;
    localparam logic [7:0] LEAD_2BYTE  = 8'hC0;
    localparam logic [7:0] MASK_4BIT   = 8'hF0;
    localparam logic [7:0] LEAD_3BYTE  = 8'hE0;
    localparam logic [7:0] MASK_5BIT   = 8'hF8;
    localparam logic [7:0] LEAD_4BYTE  = 8'hF0;

    localparam logic [20:0] SUPPLEMENTARY_BASE = 21'h10000;
    localparam logic [15:0] HIGH_SURROGATE     = 16'hD800;
    localparam logic [15:0] LOW_SURROGATE      = 16'hDC00;

    localparam logic [2:0] SEQ_NONE = 3'd0;
    localparam logic [2:0] SEQ_ONE  = 3'd1;
    localparam logic [2:0] SEQ_TWO  = 3'd2;
    localparam logic [2:0] SEQ_THREE = 3'd3;
    localparam logic [2:0] SEQ_FOUR = 3'd4;

    typedef logic [2:0] seq_len_t;

    typedef struct packed {
        logic        last;
        logic [15:0] code;
    } unit_t;

    typedef struct packed {
        logic [15:0] high;
        logic [15:0] low;
    } pair_t;

    function automatic seq_len_t lead_length(input logic [7:0] b);
        seq_len_t n;
        if (b < ASCII_LIMIT)
            n = SEQ_ONE;
        else if ((b & MASK_3BIT) == LEAD_2BYTE)
            n = SEQ_TWO;
        else if ((b & MASK_4BIT) == LEAD_3BYTE)
            n = SEQ_THREE;
        else if ((b & MASK_5BIT) == LEAD_4BYTE)
            n = SEQ_FOUR;
        else
            n = SEQ_ONE;
        return n;
    endfunction

    // halves are formed by or, not by add, so oversized code points fold into the prefix
    function automatic pair_t surrogate_pair(input logic [20:0] cp);
        logic [20:0] v;
        pair_t       p;
        v      = cp - SUPPLEMENTARY_BASE;
        p.high = HIGH_SURROGATE | {5'd0, v[20:10]};
        p.low  = LOW_SURROGATE | {6'd0, v[9:0]};
        return p;
    endfunction

endpackage

/* hw/rtl/utf8_to_utf16_transcoder.sv */
// utf-8 byte stream to utf-16 code unit stream, decode stage and result queue
// each code unit is registered in the result queue before it shows on m_tvalid
// throughput: one byte per cycle while the result queue has room for three code units;
//   the queue drains one code unit per cycle while m_tready is high, so a string end
//   that flushes up to three units stalls the input only until the queue catches up
// reset: asynchronous, clears the open sequence and empties the result queue
module utf8_to_utf16_transcoder #(
    parameter int FIFO_DEPTH = 8
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [7:0] byte_in
    input  logic        s_tlast,   // final_byte
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [15:0] m_tdata,   // [15:0] code_unit
    output logic        m_tlast    // last_unit
);
    import u8u16_pkg::*;

    localparam int AW = $clog2(FIFO_DEPTH);
    localparam int CW = $clog2(FIFO_DEPTH + 1);
    localparam logic [CW-1:0] ROOM_LIMIT = CW'(FIFO_DEPTH - UNITS_MAX);

    logic [7:0]  held_reg [0:2];
    logic [7:0]  held_next [0:2];
    logic [1:0]  held_count_reg, held_count_next;
    seq_len_t    seq_len_reg, seq_len_next;

    unit_t       queue_reg [0:FIFO_DEPTH-1];
    logic [AW-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [CW-1:0] count_reg, count_next;

    logic        in_xfer, out_xfer;
    seq_len_t    new_len;
    logic [7:0]  c1, c2;
    logic [20:0] cp;
    pair_t       pair;
    logic        full;
    unit_t       units [0:UNITS_MAX-1];
    logic [1:0]  push_num;

    assign in_xfer  = s_tvalid && s_tready;
    assign out_xfer = m_tvalid && m_tready;
    assign s_tready = (count_reg <= ROOM_LIMIT);
    assign m_tvalid = (count_reg != '0);
    assign m_tdata  = queue_reg[rd_ptr_reg].code;
    assign m_tlast  = queue_reg[rd_ptr_reg].last;

    // code point of a complete sequence, the incoming byte in the last position
    always_comb
    begin
        new_len = lead_length(s_tdata);
        c1 = (seq_len_reg == SEQ_TWO) ? s_tdata : held_reg[1];
        c2 = (seq_len_reg == SEQ_THREE) ? s_tdata : held_reg[2];
        unique case (seq_len_reg)
            SEQ_TWO:   cp = {10'd0, held_reg[0][4:0], c1[5:0]};
            SEQ_THREE: cp = {5'd0, held_reg[0][3:0], c1[5:0], c2[5:0]};
            SEQ_FOUR:  cp = {held_reg[0][2:0], c1[5:0], c2[5:0], s_tdata[5:0]};
            default:   cp = {13'd0, s_tdata};
        endcase
        pair = surrogate_pair(cp);
        full = (seq_len_reg != SEQ_NONE) && (({1'b0, held_count_reg} + 3'd1) == seq_len_reg);
    end

    always_comb
    begin
        held_next       = held_reg;
        held_count_next = held_count_reg;
        seq_len_next    = seq_len_reg;
        push_num        = 2'd0;
        for (int i = 0; i < UNITS_MAX; i++)
            units[i] = '0;

        if (in_xfer)
        begin
            if (seq_len_reg == SEQ_NONE)
            begin
                if (s_tlast || new_len == SEQ_ONE)
                begin
                    units[0].code = {8'd0, s_tdata};
                    push_num      = 2'd1;
                end
                else
                begin
                    held_next[0]    = s_tdata;
                    held_count_next = 2'd1;
                    seq_len_next    = new_len;
                end
            end
            else if (full)
            begin
                if (cp >= SUPPLEMENTARY_BASE)
                begin
                    units[0].code = pair.high;
                    units[1].code = pair.low;
                    push_num      = 2'd2;
                end
                else
                begin
                    units[0].code = cp[15:0];
                    push_num      = 2'd1;
                end
                held_count_next = 2'd0;
                seq_len_next    = SEQ_NONE;
            end
            else if (s_tlast)
            begin
                // truncated sequence: lead goes out raw, the tail is decoded again
                units[0].code = {8'd0, held_reg[0]};
                if (held_count_reg == 2'd1)
                begin
                    units[1].code = {8'd0, s_tdata};
                    push_num      = 2'd2;
                end
                else if (lead_length(held_reg[1]) == SEQ_TWO)
                begin
                    units[1].code = {5'd0, held_reg[1][4:0], s_tdata[5:0]};
                    push_num      = 2'd2;
                end
                else
                begin
                    units[1].code = {8'd0, held_reg[1]};
                    units[2].code = {8'd0, s_tdata};
                    push_num      = 2'd3;
                end
            end
            else
            begin
                held_next[held_count_reg] = s_tdata;
                held_count_next           = held_count_reg + 2'd1;
            end

            if (s_tlast)
            begin
                held_count_next = 2'd0;
                seq_len_next    = SEQ_NONE;
                for (int i = 0; i < UNITS_MAX; i++)
                    if (2'(i) == push_num - 2'd1)
                        units[i].last = 1'b1;
            end
        end

        count_next = count_reg + CW'(push_num) - CW'(out_xfer);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < 3; i++)
                held_reg[i] <= 8'd0;
            held_count_reg <= 2'd0;
            seq_len_reg    <= SEQ_NONE;
            wr_ptr_reg     <= '0;
            rd_ptr_reg     <= '0;
            count_reg      <= '0;
        end
        else
        begin
            held_reg       <= held_next;
            held_count_reg <= held_count_next;
            seq_len_reg    <= seq_len_next;
            wr_ptr_reg     <= wr_ptr_reg + AW'(push_num);
            if (out_xfer)
                rd_ptr_reg <= rd_ptr_reg + AW'(1);
            count_reg      <= count_next;
        end
    end

    // result queue, up to three code units written per transfer
    always_ff @(posedge clk)
    begin
        for (int i = 0; i < UNITS_MAX; i++)
            if (2'(i) < push_num)
                queue_reg[wr_ptr_reg + AW'(i)] <= units[i];
    end

`ifndef SYNTHESIS
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CW'(FIFO_DEPTH))
        else $error("result queue count beyond depth");

    a_held_consistent: assert property (@(posedge clk) disable iff (!rst_n)
        (seq_len_reg == SEQ_NONE) ? (held_count_reg == 2'd0)
                                  : ({1'b0, held_count_reg} < seq_len_reg))
        else $error("held byte count does not match open sequence");

    a_final_clears: assert property (@(posedge clk) disable iff (!rst_n)
        in_xfer && s_tlast |=> seq_len_reg == SEQ_NONE && held_count_reg == 2'd0)
        else $error("sequence state not cleared after final byte");
`endif

endmodule

/* tb/sv/tb_top.sv */
// testbench for the utf-8 to utf-16 transcoder: directed strings, random text, drain pause
`timescale 1ns / 100ps

module tb_top;

    localparam int unsigned STALL_LIMIT = 2000;
    localparam int unsigned SETTLE_CYCLES = 20;
    localparam int unsigned REPORT_LIMIT = 10;

    typedef enum logic [1:0] {
        RX_OPEN,
        RX_LIGHT,
        RX_HEAVY,
        RX_PERIODIC
    } rx_mode_t;

    typedef enum logic [1:0] {
        TEXT_CLEAN,
        TEXT_TRUNCATED,
        TEXT_NOISE,
        TEXT_CORRUPTED
    } text_kind_t;

    typedef struct packed {
        logic        last;
        logic [15:0] code;
    } unit_rec_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [7:0]  s_tdata = 8'h00;     // [7:0] byte_in
    logic        s_tlast = 1'b0;      // final_byte
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [15:0] m_tdata;             // [15:0] code_unit
    logic        m_tlast;             // last_unit

    // decoder state mirrored by the predictor
    logic [7:0]  pend_bytes [3];
    int unsigned pend_count = 0;
    int unsigned open_len = 0;
    logic [7:0]  work_buf [4];

    logic [15:0] step_units [$];
    unit_rec_t   expected_units [$];
    logic [7:0]  text_bytes [$];

    int unsigned sent_bytes = 0;
    int unsigned error_count = 0;
    int unsigned burst_left = 0;
    int unsigned idle_cycles = 0;
    int unsigned rx_left = 0;
    int unsigned rx_phase = 0;
    rx_mode_t    rx_mode = RX_OPEN;
    unit_rec_t   want_unit;

    utf8_to_utf16_transcoder dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast)
    );

    always #5 clk = ~clk;

    function automatic int unsigned seq_bytes(input logic [7:0] b);
        if (b[7] == 1'b0)
            return 1;
        if (b[7:5] == 3'b110)
            return 2;
        if (b[7:4] == 4'b1110)
            return 3;
        if (b[7:3] == 5'b11110)
            return 4;
        return 1;
    endfunction

    // follower bytes only lose their top two bits
    function automatic logic [20:0] join_point(input int unsigned at, input int unsigned n);
        case (n)
            2: return {10'd0, work_buf[at][4:0], work_buf[at+1][5:0]};
            3: return {5'd0, work_buf[at][3:0], work_buf[at+1][5:0], work_buf[at+2][5:0]};
            4: return {work_buf[at][2:0], work_buf[at+1][5:0], work_buf[at+2][5:0],
                       work_buf[at+3][5:0]};
            default: return {13'd0, work_buf[at]};
        endcase
    endfunction

    // pair halves are or-ed into the prefix, so points above 0x10ffff fold
    function automatic void push_point(input logic [20:0] cp);
        logic [20:0] v;
        if (cp >= 21'h10000)
        begin
            v = cp - 21'h10000;
            step_units.push_back(16'hD800 | {5'd0, v[20:10]});
            step_units.push_back(16'hDC00 | {6'd0, v[9:0]});
        end
        else
        begin
            step_units.push_back(cp[15:0]);
        end
    endfunction

    function automatic void clear_decoder();
        pend_bytes[0] = 8'h00;
        pend_bytes[1] = 8'h00;
        pend_bytes[2] = 8'h00;
        pend_count = 0;
        open_len = 0;
    endfunction

    function automatic void predict_byte(input logic [7:0] b, input logic fin);
        int unsigned i;
        int unsigned span;
        int unsigned at;
        int unsigned n;
        unit_rec_t   rec;
        step_units.delete();
        for (i = 0; i < pend_count; i++)
            work_buf[i] = pend_bytes[i];
        work_buf[pend_count] = b;
        span = pend_count + 1;
        if (fin)
        begin
            // string end: decode what is held, unfinished leads go out raw
            at = 0;
            while (at < span)
            begin
                n = seq_bytes(work_buf[at]);
                if (at + n <= span)
                begin
                    push_point(join_point(at, n));
                end
                else
                begin
                    push_point({13'd0, work_buf[at]});
                    n = 1;
                end
                at += n;
            end
            clear_decoder();
        end
        else if (open_len == 0)
        begin
            n = seq_bytes(b);
            if (n == 1)
            begin
                push_point({13'd0, b});
            end
            else
            begin
                pend_bytes[0] = b;
                pend_count = 1;
                open_len = n;
            end
        end
        else if (span >= open_len)
        begin
            push_point(join_point(0, open_len));
            clear_decoder();
        end
        else
        begin
            pend_bytes[pend_count] = b;
            pend_count++;
        end
        for (i = 0; i < step_units.size(); i++)
        begin
            rec.code = step_units[i];
            rec.last = fin && (i == step_units.size() - 1);
            expected_units.push_back(rec);
        end
    endfunction

    function automatic void append_point(input logic [20:0] cp);
        if (cp < 21'h80)
        begin
            text_bytes.push_back(cp[7:0]);
        end
        else if (cp < 21'h800)
        begin
            text_bytes.push_back({3'b110, cp[10:6]});
            text_bytes.push_back({2'b10, cp[5:0]});
        end
        else if (cp < 21'h10000)
        begin
            text_bytes.push_back({4'b1110, cp[15:12]});
            text_bytes.push_back({2'b10, cp[11:6]});
            text_bytes.push_back({2'b10, cp[5:0]});
        end
        else
        begin
            text_bytes.push_back({5'b11110, cp[20:18]});
            text_bytes.push_back({2'b10, cp[17:12]});
            text_bytes.push_back({2'b10, cp[11:6]});
            text_bytes.push_back({2'b10, cp[5:0]});
        end
    endfunction

    function automatic logic [20:0] random_point();
        case ($urandom_range(0, 3))
            0: return 21'($urandom_range(1, 'h7F));
            1: return 21'($urandom_range('h80, 'h7FF));
            2: return 21'($urandom_range('h800, 'hFFFF));
            default:
            begin
                if ($urandom_range(0, 7) == 0)
                    return 21'($urandom_range('h110000, 'h1FFFFF));
                return 21'($urandom_range('h10000, 'h10FFFF));
            end
        endcase
    endfunction

    task automatic flag_mismatch(input string what, input logic [15:0] want,
                                 input logic [15:0] got);
        error_count++;
        if (error_count <= REPORT_LIMIT)
            $display("mismatch on %s at %0t: expected %h, got %h", what, $time, want, got);
    endtask

    task automatic send_byte(input logic [7:0] b, input logic fin);
        int unsigned gap;
        s_tvalid <= 1'b1;
        s_tdata <= b;
        s_tlast <= fin;
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        predict_byte(b, fin);
        sent_bytes++;
        if (burst_left > 0)
            burst_left--;
        if (burst_left == 0)
        begin
            // some bursts run long with no gap at all
            if ($urandom_range(0, 2) == 0)
            begin
                burst_left = $urandom_range(20, 60);
                gap = 0;
            end
            else
            begin
                burst_left = $urandom_range(1, 12);
                gap = $urandom_range(1, 6);
            end
            if (gap != 0)
            begin
                s_tvalid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
        end
    endtask

    task automatic send_text();
        int unsigned i;
        for (i = 0; i < text_bytes.size(); i++)
            send_byte(text_bytes[i], i == text_bytes.size() - 1);
        text_bytes.delete();
    endtask

    task automatic build_random_text();
        text_kind_t  kind;
        int unsigned count;
        int unsigned i;
        int unsigned pick;
        pick = $urandom_range(0, 9);
        if (pick < 6)
            kind = TEXT_CLEAN;
        else if (pick < 7)
            kind = TEXT_TRUNCATED;
        else if (pick < 8)
            kind = TEXT_CORRUPTED;
        else
            kind = TEXT_NOISE;
        text_bytes.delete();
        if (kind == TEXT_NOISE)
        begin
            count = $urandom_range(1, 8);
            for (i = 0; i < count; i++)
                text_bytes.push_back(8'($urandom_range(0, 255)));
        end
        else
        begin
            count = $urandom_range(1, 10);
            for (i = 0; i < count; i++)
                append_point(random_point());
            if (kind == TEXT_TRUNCATED && text_bytes.size() > 2)
            begin
                count = $urandom_range(1, 2);
                for (i = 0; i < count; i++)
                    void'(text_bytes.pop_back());
            end
            if (kind == TEXT_CORRUPTED)
                text_bytes[$urandom_range(0, text_bytes.size() - 1)] =
                    8'($urandom_range(0, 255));
        end
    endtask

    task automatic test_directed();
        // ascii extremes including zero, two-byte extremes
        text_bytes = '{8'h00, 8'hC2, 8'h80, 8'hDF, 8'hBF, 8'h7F};
        send_text();
        // three-byte max, four-byte surrogates, oversized point folding into the prefix
        text_bytes = '{8'hEF, 8'hBF, 8'hBF, 8'hF0, 8'h90, 8'h80, 8'h80,
                       8'hF7, 8'hBF, 8'hBF, 8'hBF};
        send_text();
        // invalid leads pass through, follower with wrong tag bits still masked
        text_bytes = '{8'h80, 8'hFF, 8'hF8, 8'hC3, 8'h41};
        send_text();
        // string ends inside a sequence whose held bytes start another one
        text_bytes = '{8'hF0, 8'hC3, 8'h80};
        send_text();
        // lone lead as the final byte
        text_bytes = '{8'hE2};
        send_text();
    endtask

    task automatic test_random_text(input int unsigned items);
        int unsigned target;
        target = sent_bytes + items;
        while (sent_bytes < target)
        begin
            build_random_text();
            send_text();
        end
    endtask

    task automatic test_drain_pause();
        build_random_text();
        send_text();
        s_tvalid <= 1'b0;
        while (expected_units.size() != 0)
            @(posedge clk);
        build_random_text();
        send_text();
    endtask

    // receiver stall patterns change at random, each mode held until rx_left counts down
    always @(posedge clk)
    begin
        if (rx_left == 0)
        begin
            rx_mode <= rx_mode_t'($urandom_range(0, 3));
            rx_left <= $urandom_range(20, 120);
        end
        else
        begin
            rx_left <= rx_left - 1;
        end
        rx_phase <= rx_phase + 1;
        case (rx_mode)
            RX_OPEN:   m_tready <= 1'b1;
            RX_LIGHT:  m_tready <= ($urandom_range(0, 3) != 0);
            RX_HEAVY:  m_tready <= ($urandom_range(0, 3) == 0);
            default:   m_tready <= ((rx_phase % 5) != 0);
        endcase
    end

    always @(posedge clk)
    begin
        if (rst_n && m_tvalid && m_tready)
        begin
            if (expected_units.size() == 0)
            begin
                flag_mismatch("unexpected transfer", 16'h0000, m_tdata);
            end
            else
            begin
                want_unit = expected_units.pop_front();
                if (m_tdata !== want_unit.code)
                    flag_mismatch("code_unit", want_unit.code, m_tdata);
                if (m_tlast !== want_unit.last)
                    flag_mismatch("last_unit", {15'd0, want_unit.last}, {15'd0, m_tlast});
            end
        end
    end

    always @(posedge clk)
    begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= STALL_LIMIT)
        begin
            $display("TEST FAILED");
            $finish;
        end
    end

    initial
    begin
        clear_decoder();
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_directed();
        test_random_text(160);
        test_drain_pause();
        test_random_text(160);
        s_tvalid <= 1'b0;
        while (expected_units.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
        if (expected_units.size() != 0)
            error_count++;
        if (error_count == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule
